// File: src/sm3_hash_engine_assert.svh
// assertion macros shared by the sm3 hash engine checker
// no dependencies
`ifndef SM3_HASH_ENGINE_ASSERT_SVH
`define SM3_HASH_ENGINE_ASSERT_SVH

// property held on every clock unless in reset
`define SM3_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication shorthand
`define SM3_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sm3_pkg.sv
// shared types and constants for the sm3 hash engine
// no dependencies
`default_nettype none
package sm3_pkg;
  typedef logic [31:0] word_t;
  localparam word_t T_LOW = 32'h79cc4519;
  localparam word_t T_HIGH = 32'h7a879d8a;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [255:0] SM3_IV = {32'h7380166f, 32'h4914b2b9, 32'h172442d7,
    32'hda8a0600, 32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

  // entry between front and back: one block word, flag marks final block word
  typedef struct packed {
    word_t w;
    logic  fin;
  } qent_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    begin
      d = {x, x} << n;
      rotl = d[63:32];
    end
  endfunction

  function automatic word_t perm0(input word_t x);
    perm0 = x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
  endfunction

  function automatic word_t perm1(input word_t x);
    perm1 = x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
  endfunction
endpackage
`default_nettype wire

// File: src/sm3_front.sv
// front end: accepts message words, counts length, generates padding words
// depends on sm3_pkg
`default_nettype none
module sm3_front import sm3_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_tvalid,
  output logic       in_tready,
  input  wire word_t in_data,
  input  wire logic [2:0] in_cnt,
  input  wire logic  in_last,
  output logic       q_valid,
  input  wire logic  q_ready,
  output qent_t      q_ent
);
  localparam logic [1:0] S_IN = 2'd0, S_MARK = 2'd1, S_ZERO = 2'd2, S_LEN = 2'd3;
  logic [1:0]  state_r, state_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic        lenlo_r, lenlo_nxt;
  logic [2:0]  n;
  word_t       keep, padw;

  always_comb begin
    n = (in_cnt > 3'd4) ? 3'd4 : in_cnt;
    keep = (n == 3'd0) ? 32'h0 : (32'hffffffff << (6'd32 - {n, 3'b000}));
    padw = (in_data & keep) | ({24'h0, PAD_MARK} << (5'd24 - {n[1:0], 3'b000}));
  end

  assign in_tready = (state_r == S_IN) && q_ready;

  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r;
    bits_nxt = bits_r;
    lenlo_nxt = lenlo_r;
    q_valid = 1'b0;
    q_ent.w = in_data;
    q_ent.fin = 1'b0;
    case (state_r)
      S_IN: begin
        q_valid = in_tvalid;
        if (in_tvalid && in_last && (n != 3'd4)) q_ent.w = padw;
        if (in_tvalid && q_ready) begin
          fill_nxt = fill_r + 4'd1;
          if (!in_last) bits_nxt = bits_r + 64'd32;
          else begin
            bits_nxt = bits_r + {58'h0, n, 3'b000};
            if (n == 3'd4) state_nxt = S_MARK;
            else state_nxt = (fill_r + 4'd1 == 4'd14) ? S_LEN : S_ZERO;
          end
        end
      end
      S_MARK: begin
        q_valid = 1'b1;
        q_ent.w = {PAD_MARK, 24'h0};
        if (q_ready) begin
          fill_nxt = fill_r + 4'd1;
          state_nxt = (fill_r + 4'd1 == 4'd14) ? S_LEN : S_ZERO;
        end
      end
      S_ZERO: begin
        q_valid = 1'b1;
        q_ent.w = '0;
        if (q_ready) begin
          fill_nxt = fill_r + 4'd1;
          if (fill_r + 4'd1 == 4'd14) state_nxt = S_LEN;
        end
      end
      default: begin
        q_valid = 1'b1;
        q_ent.w = lenlo_r ? bits_r[31:0] : bits_r[63:32];
        q_ent.fin = lenlo_r;
        if (q_ready) begin
          fill_nxt = fill_r + 4'd1;
          lenlo_nxt = !lenlo_r;
          if (lenlo_r) begin
            state_nxt = S_IN;
            bits_nxt = '0;
            fill_nxt = '0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IN;
      fill_r <= '0;
      bits_r <= '0;
      lenlo_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      bits_r <= bits_nxt;
      lenlo_r <= lenlo_nxt;
    end
  end
endmodule
`default_nettype wire

// File: src/sm3_queue.sv
// two-entry queue between front end and compression core
// depends on sm3_pkg
`default_nettype none
module sm3_queue import sm3_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  input  wire qent_t wr_ent,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output qent_t      rd_ent
);
  qent_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_ent = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

// File: src/sm3_core.sv
// compression core: fills block, runs 64 rounds, emits digest words
// depends on sm3_pkg
`default_nettype none
module sm3_core import sm3_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire qent_t q_ent,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  output word_t      out_word,
  output logic [2:0] out_idx,
  output logic       out_end
);
  localparam logic [1:0] S_FILL = 2'd0, S_RUN = 2'd1, S_FOLD = 2'd2, S_OUT = 2'd3;
  logic [1:0] state_r;
  logic [3:0] fill_r;
  logic [5:0] rnd_r;
  logic       fin_r;
  logic [2:0] oidx_r;
  word_t      w_r [16];
  word_t      v_r [8];
  word_t      cv_r [8];
  word_t      wn, wj, wpj, t, a12, ss1, ss2, ffv, ggv, tt1, tt2;
  logic       hi;

  assign q_ready = (state_r == S_FILL);
  assign out_tvalid = (state_r == S_OUT);
  assign out_word = cv_r[oidx_r];
  assign out_idx = oidx_r;
  assign out_end = (oidx_r == 3'd7);

  always_comb begin
    hi = rnd_r[5] | rnd_r[4];
    wj = w_r[0];
    wn = perm1(w_r[0] ^ w_r[7] ^ rotl(w_r[13], 5'd15)) ^ rotl(w_r[3], 5'd7) ^ w_r[10];
    wpj = w_r[0] ^ w_r[4];
    t = hi ? T_HIGH : T_LOW;
    a12 = rotl(v_r[0], 5'd12);
    ss1 = rotl(a12 + v_r[4] + rotl(t, rnd_r[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    ffv = hi ? ((v_r[0] & v_r[1]) | (v_r[0] & v_r[2]) | (v_r[1] & v_r[2]))
             : (v_r[0] ^ v_r[1] ^ v_r[2]);
    ggv = hi ? ((v_r[4] & v_r[5]) | (~v_r[4] & v_r[6])) : (v_r[4] ^ v_r[5] ^ v_r[6]);
    tt1 = ffv + v_r[3] + ss2 + wpj;
    tt2 = ggv + v_r[7] + ss1 + wj;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_FILL: begin
        if (q_valid) begin
          w_r[fill_r] <= q_ent.w;
          if (fill_r == 4'd15) begin
            for (int i = 0; i < 8; i++) v_r[i] <= cv_r[i];
          end
        end
      end
      S_RUN: begin
        // message schedule slides one word per round
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wn;
        v_r[0] <= tt1;
        v_r[1] <= v_r[0];
        v_r[2] <= rotl(v_r[1], 5'd9);
        v_r[3] <= v_r[2];
        v_r[4] <= perm0(tt2);
        v_r[5] <= v_r[4];
        v_r[6] <= rotl(v_r[5], 5'd19);
        v_r[7] <= v_r[6];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      fill_r <= '0;
      rnd_r <= '0;
      fin_r <= 1'b0;
      oidx_r <= '0;
      for (int i = 0; i < 8; i++) cv_r[i] <= SM3_IV[255-32*i -: 32];
    end else begin
      case (state_r)
        S_FILL: begin
          if (q_valid) begin
            fill_r <= fill_r + 4'd1;
            if (fill_r == 4'd15) begin
              fin_r <= q_ent.fin;
              rnd_r <= '0;
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) cv_r[i] <= cv_r[i] ^ v_r[i];
          oidx_r <= '0;
          state_r <= fin_r ? S_OUT : S_FILL;
        end
        default: begin
          if (out_tready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              state_r <= S_FILL;
              for (int i = 0; i < 8; i++) cv_r[i] <= SM3_IV[255-32*i -: 32];
            end
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/sm3_hash_engine.sv
// Streaming SM3 hash engine. Each input transfer carries one big-endian
// message word; in_tuser holds {byte_count} and in_tlast marks the final word.
// The core loads one word per cycle into its block buffer while it is
// filling and the queue holds a word; every sixteenth word starts a
// 64-round compression (one round per cycle, then a fold step) during which
// the two-entry queue takes at most two more words before input stalls.
// A final word adds padding words, one or two compressions,
// then eight digest transfers, word 0 first, tlast on word 7.
// depends on sm3_pkg, sm3_front, sm3_queue, sm3_core
`default_nettype none
module sm3_hash_engine import sm3_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // data_word
  input  wire logic [2:0]  in_tuser,  // byte_count
  input  wire logic        in_tlast,  // last_word
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata, // digest_word
  output logic [2:0]       out_tuser, // word_index
  output logic             out_tlast  // digest_end
);
  logic  fq_valid, fq_ready, qc_valid, qc_ready;
  qent_t fq_ent, qc_ent;

  sm3_front u_front (.clk, .rst_n, .in_tvalid, .in_tready, .in_data(in_tdata),
    .in_cnt(in_tuser), .in_last(in_tlast), .q_valid(fq_valid), .q_ready(fq_ready),
    .q_ent(fq_ent));
  sm3_queue u_queue (.clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready),
    .wr_ent(fq_ent), .rd_valid(qc_valid), .rd_ready(qc_ready), .rd_ent(qc_ent));
  sm3_core u_core (.clk, .rst_n, .q_valid(qc_valid), .q_ready(qc_ready), .q_ent(qc_ent),
    .out_tvalid, .out_tready, .out_word(out_tdata), .out_idx(out_tuser),
    .out_end(out_tlast));
endmodule
`default_nettype wire

// File: src/sm3_hash_engine_checker.sv
// port-level checker for the sm3 hash engine, bound to the top level
// depends on sm3_hash_engine_assert.svh
`default_nettype none
`include "sm3_hash_engine_assert.svh"
module sm3_hash_engine_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [2:0] out_tuser,
  input wire logic       out_tlast
);
  `SM3_ASSERT_CLK(a_last_idx, !out_tvalid || (out_tlast == (out_tuser == 3'd7)), "tlast mismatch")
  `SM3_ASSERT_IMP(a_stall, out_tvalid && !out_tready, out_tvalid && $stable(out_tuser), "stall dropped")
  `SM3_ASSERT_IMP(a_step, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tuser == $past(out_tuser) + 3'd1), "index skipped")
endmodule

bind sm3_hash_engine sm3_hash_engine_checker u_chk (.clk, .rst_n, .out_tvalid,
  .out_tready, .out_tuser, .out_tlast);
`default_nettype wire

// File: test/tb_sm3_hash_engine.sv
// self-checking testbench for sm3_hash_engine: directed and random messages with a local sm3 digest model
// depends on sm3_pkg and the sm3_hash_engine rtl
`default_nettype none
module tb_sm3_hash_engine;
  import sm3_pkg::*;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        fin;
  } msg_word_t;

  typedef struct packed {
    logic [31:0] dig;
    logic [2:0]  idx;
    logic        fin;
  } digest_beat_t;

  logic clk;
  logic rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [31:0] in_tdata;
  logic [2:0] in_tuser;
  logic out_tvalid, out_tready, out_tlast;
  logic [31:0] out_tdata;
  logic [2:0] out_tuser;

  sm3_hash_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  msg_word_t pending_words[$];
  digest_beat_t expected_digest[$];

  // hash state of the predictor
  logic [31:0] hv[8];
  logic [31:0] blk[16];
  int unsigned blk_fill;
  logic [63:0] msg_len_bits;

  int errors = 0;
  int mismatches = 0;
  int cycles = 0;
  int hold_cycles = 0;
  bit stim_done = 0;
  bit in_fire = 0;

  initial begin
    clk = 0;
    forever begin
      #5 clk = 1;
      #5 clk = 0;
    end
  end

  function automatic logic [31:0] rl(input logic [31:0] x, input int n);
    int m;
    m = n % 32;
    if (m == 0) return x;
    return (x << m) | (x >> (32 - m));
  endfunction

  task automatic compress_block();
    logic [31:0] w[68];
    logic [31:0] v[8];
    logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, tj;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 68; j++) begin
      tj = w[j-16] ^ w[j-9] ^ rl(w[j-3], 15);
      w[j] = (tj ^ rl(tj, 15) ^ rl(tj, 23)) ^ rl(w[j-13], 7) ^ w[j-6];
    end
    for (int j = 0; j < 8; j++) v[j] = hv[j];
    for (int j = 0; j < 64; j++) begin
      tj = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
      a12 = rl(v[0], 12);
      ss1 = rl(a12 + v[4] + rl(tj, j), 7);
      ss2 = ss1 ^ a12;
      ffv = (j < 16) ? (v[0] ^ v[1] ^ v[2]) : ((v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]));
      ggv = (j < 16) ? (v[4] ^ v[5] ^ v[6]) : ((v[4] & v[5]) | (~v[4] & v[6]));
      tt1 = ffv + v[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = ggv + v[7] + ss1 + w[j];
      v[3] = v[2]; v[2] = rl(v[1], 9); v[1] = v[0]; v[0] = tt1;
      v[7] = v[6]; v[6] = rl(v[5], 19); v[5] = v[4];
      v[4] = tt2 ^ rl(tt2, 9) ^ rl(tt2, 17);
    end
    for (int j = 0; j < 8; j++) hv[j] ^= v[j];
  endtask

  task automatic append_word(input logic [31:0] w);
    blk[blk_fill] = w;
    blk_fill++;
    if (blk_fill == 16) begin
      compress_block();
      blk_fill = 0;
    end
  endtask

  task automatic restart_message();
    for (int k = 0; k < 8; k++) hv[k] = SM3_IV[255 - 32*k -: 32];
    blk_fill = 0;
    msg_len_bits = 0;
  endtask

  task automatic hash_word(input msg_word_t it);
    int unsigned n;
    logic [31:0] keep;
    digest_beat_t b;
    if (!it.fin) begin
      msg_len_bits += 32;
      append_word(it.data);
    end else begin
      n = (it.nbytes > 4) ? 4 : it.nbytes;
      msg_len_bits += 8 * n;
      if (n == 4) begin
        append_word(it.data);
        append_word({PAD_MARK, 24'h0});
      end else begin
        keep = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8*n));
        append_word((it.data & keep) | (32'(PAD_MARK) << (24 - 8*n)));
      end
      while (blk_fill != 14) append_word(32'h0);
      append_word(msg_len_bits[63:32]);
      append_word(msg_len_bits[31:0]);
      for (int k = 0; k < 8; k++) begin
        b.dig = hv[k];
        b.idx = 3'(k);
        b.fin = (k == 7);
        expected_digest.push_back(b);
      end
      restart_message();
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // input transfer seen at the rising edge
  always @(posedge clk) begin
    in_fire = rst_n && in_tvalid && in_tready;
  end

  // sender
  int tx_gap = 0;
  initial begin
    in_tvalid = 0; in_tdata = 0; in_tuser = 0; in_tlast = 0;
  end
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) begin
        hash_word(pending_words.pop_front());
        tx_gap = gap_len();
        if (pending_words.size() == 0) stim_done = 1;
      end
      if (!in_tvalid || in_fire) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 0;
        end else if (pending_words.size() > 0) begin
          in_tvalid <= 1;
          in_tdata <= pending_words[0].data;
          in_tuser <= pending_words[0].nbytes;
          in_tlast <= pending_words[0].fin;
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // receiver back-pressure
  initial out_tready = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 0;
      end else if (cycles > 300 && cycles < 305) begin
        hold_cycles = 1500;
        out_tready <= 0;
      end else begin
        out_tready <= ($urandom_range(0, 9) < 7) || (cycles % 400 < 100);
      end
    end
  end

  // digest checker
  digest_beat_t exp_b;
  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_digest.size() == 0) begin
        errors++;
        if (mismatches < 10)
          $display("unexpected digest transfer %h idx %0d", out_tdata, out_tuser);
        mismatches++;
      end else begin
        exp_b = expected_digest.pop_front();
        if (out_tdata !== exp_b.dig || out_tuser !== exp_b.idx || out_tlast !== exp_b.fin) begin
          errors++;
          if (mismatches < 10)
            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
              exp_b.dig, exp_b.idx, exp_b.fin, out_tdata, out_tuser, out_tlast);
          mismatches++;
        end
      end
    end
  end

  task automatic add_message(input int nwords, input logic [2:0] nb, input bit edge_data);
    msg_word_t it;
    for (int i = 0; i < nwords; i++) begin
      it.data = edge_data ? ((i % 2) ? 32'hffffffff : 32'h0) : $urandom;
      it.nbytes = 3'($urandom_range(0, 7));
      it.fin = (i == nwords - 1);
      if (it.fin) it.nbytes = nb;
      pending_words.push_back(it);
    end
  endtask

  initial begin
    int r;
    rst_n = 0;
    restart_message();
    // directed: every byte count on the last word, one block boundary length
    add_message(1, 3'd0, 1);
    add_message(1, 3'd4, 0);
    add_message(2, 3'd1, 1);
    add_message(1, 3'd2, 0);
    add_message(1, 3'd3, 0);
    add_message(1, 3'd7, 1);
    add_message(1, 3'd5, 0);
    add_message(14, 3'd6, 1);
    repeat (11) @(posedge clk);
    rst_n <= 1;
    // random messages, mostly short, a few spanning several blocks
    while (pending_words.size() < 165) begin
      r = $urandom_range(0, 9);
      if (r < 7) add_message($urandom_range(1, 6), 3'($urandom_range(0, 7)), 0);
      else add_message($urandom_range(13, 34), 3'($urandom_range(0, 7)), 0);
    end
  end

  initial begin
    wait (stim_done);
    while (expected_digest.size() != 0 && cycles < 400000) @(posedge clk);
    repeat (200) @(posedge clk);
    if (cycles >= 400000) begin
      $display("RESULT: ERROR");
    end else if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > 500000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end
endmodule
`default_nettype wire
